// File: hdl/hks_pkg.sv
// Shared constants for the hashed key set: hash multiplier, key width, codes and parameter defaults.
package hks_pkg;

    localparam int          KEY_W       = 32;
    localparam logic [31:0] HASH_MULT   = 32'h9E37_79B1;
    localparam int          BUCKETS_DEF = 64;
    localparam int          WAYS_DEF    = 4;

    // Command codes carried in the low bits of the input item.
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_SPARE  = 2'd3
    } cmd_t;

    typedef enum logic {
        KIND_INT   = 1'b0,
        KIND_FLOAT = 1'b1
    } key_kind_t;

    typedef enum logic {
        STAT_DONE    = 1'b0,
        STAT_DROPPED = 1'b1
    } status_t;

endpackage

// File: hdl/hks_bucket_calc.sv
// Bucket index unit: one shared 32x32 multiplier sequenced for hash, reciprocal and remainder.
module hks_bucket_calc
    import hks_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             done,
    output logic [BW-1:0]    bucket
);

    // Reciprocal of the bucket count scaled by 2^32; the quotient estimate is low by at most one.
    localparam logic [63:0] RECIP_WIDE = 64'h1_0000_0000 / 64'(BUCKETS);
    localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
    localparam logic [31:0] NB         = 32'(BUCKETS);

    typedef enum logic [2:0] {
        C_IDLE,
        C_HASH,
        C_QUOT,
        C_PROD,
        C_REDUCE
    } calc_state_t;

    calc_state_t state_reg;
    logic [31:0] opa_reg;
    logic [31:0] opb_reg;
    logic [31:0] hash_reg;
    logic [BW-1:0] bucket_reg;
    logic        done_reg;

    logic [63:0] prod;
    logic [31:0] diff;
    logic [31:0] rem;

    assign prod = 64'(opa_reg) * 64'(opb_reg);

    // The remainder estimate is below twice the bucket count, so one correction suffices.
    always_comb begin
        diff = hash_reg - opa_reg;
        rem  = (diff >= NB) ? (diff - NB) : diff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == C_REDUCE);
            unique case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        opa_reg   <= key;
                        opb_reg   <= HASH_MULT;
                        state_reg <= C_HASH;
                    end
                end
                C_HASH: begin
                    hash_reg  <= prod[31:0];
                    opa_reg   <= prod[31:0];
                    opb_reg   <= RECIP;
                    state_reg <= C_QUOT;
                end
                C_QUOT: begin
                    opa_reg   <= prod[63:32];
                    opb_reg   <= NB;
                    state_reg <= C_PROD;
                end
                C_PROD: begin
                    opa_reg   <= prod[31:0];
                    state_reg <= C_REDUCE;
                end
                C_REDUCE: begin
                    bucket_reg <= rem[BW-1:0];
                    state_reg  <= C_IDLE;
                end
                default: begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

// File: hdl/hashed_key_set.sv
// Top level of the hashed key set: stream ports, bucket memories, match logic and sequencer.
// A result item is ready once its input item has passed the shared multiplier (hash,
// reciprocal quotient, product, remainder correction), the bucket row read and the decide
// step, which waits while an earlier result is still not taken. The block takes one item
// at a time, since the bucket row is read and written back before the next item is accepted.
// Reset: synchronous, active low; afterward a clearing pass zeroes the valid marks of every
// bucket row, and no item is accepted until it is finished.
module hashed_key_set
    import hks_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int WAYS    = WAYS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input item: tdata[1:0] command, tdata[33:2] key_bits, tdata[39:34] zero.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    // tuser[0] key_kind.
    input  logic [0:0]  s_tuser,
    // Result item: tdata[0] was_present, tdata[1] status, tdata[7:2] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASHING,
        S_DECIDE
    } state_t;

    typedef logic [WAYS-1:0][KEY_W-1:0] key_row_t;

    // Each bucket is one row holding all of its ways.
    logic [WAYS-1:0] valid_mem [BUCKETS];
    logic [WAYS-1:0] kind_mem  [BUCKETS];
    key_row_t        key_mem   [BUCKETS];

    state_t           state_reg;
    logic [BW-1:0]    clr_cnt_reg;
    logic [1:0]       cmd_reg;
    logic             kind_reg;
    logic [KEY_W-1:0] key_reg;
    logic             m_tvalid_reg;
    logic             present_reg;
    logic             status_reg;

    logic [WAYS-1:0]  valid_row_reg;
    logic [WAYS-1:0]  kind_row_reg;
    key_row_t         key_row_reg;

    logic             accept;
    logic             calc_done;
    logic [BW-1:0]    bucket;
    logic             rd_en;
    logic             commit;

    logic             hit_found;
    logic [WW-1:0]    hit_idx;
    logic             free_found;
    logic [WW-1:0]    free_idx;
    logic [WAYS-1:0]  valid_next;
    logic [WAYS-1:0]  kind_next;
    key_row_t         key_next;
    logic             status_next;

    logic             vld_we;
    logic [BW-1:0]    vld_addr;
    logic [WAYS-1:0]  vld_wdata;

    // Float keys compare by bit pattern, except that NaN never matches and the two zeros do.
    function automatic logic keys_match(input logic kind, input logic [KEY_W-1:0] a,
                                        input logic [KEY_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        a_nan     = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan     = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (kind == KIND_INT) begin
            return a == b;
        end
        if (a_nan || b_nan) begin
            return 1'b0;
        end
        return both_zero || (a == b);
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    hks_bucket_calc #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_calc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key     (s_tdata[33:2]),
        .done    (calc_done),
        .bucket  (bucket)
    );

    // The bucket index stays on the calc output until the next item starts.
    assign rd_en  = (state_reg == S_HASHING) && calc_done;
    assign commit = (state_reg == S_DECIDE) && (!m_tvalid_reg || m_tready);

    // Scan the row: lowest free way and lowest matching valid way.
    always_comb begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!valid_row_reg[w]) begin
                if (!free_found) begin
                    free_found = 1'b1;
                    free_idx   = WW'(w);
                end
            end else if (!hit_found && (kind_row_reg[w] == kind_reg) &&
                         keys_match(kind_reg, key_row_reg[w], key_reg)) begin
                hit_found = 1'b1;
                hit_idx   = WW'(w);
            end
        end
    end

    always_comb begin
        valid_next  = valid_row_reg;
        kind_next   = kind_row_reg;
        key_next    = key_row_reg;
        status_next = STAT_DONE;
        if (cmd_reg == CMD_ADD) begin
            if (!hit_found) begin
                if (free_found) begin
                    valid_next[free_idx] = 1'b1;
                    kind_next[free_idx]  = kind_reg;
                    key_next[free_idx]   = key_reg;
                end else begin
                    status_next = STAT_DROPPED;
                end
            end
        end else if (cmd_reg == CMD_REMOVE) begin
            if (hit_found) begin
                valid_next[hit_idx] = 1'b0;
            end
        end
    end

    // The valid memory has one write port shared by the clearing pass and the write-back.
    assign vld_we    = (state_reg == S_CLEAR) || commit;
    assign vld_addr  = (state_reg == S_CLEAR) ? clr_cnt_reg : bucket;
    assign vld_wdata = (state_reg == S_CLEAR) ? '0 : valid_next;

    always_ff @(posedge aclk) begin
        if (vld_we) begin
            valid_mem[vld_addr] <= vld_wdata;
        end
        if (rd_en) begin
            valid_row_reg <= valid_mem[bucket];
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            kind_mem[bucket] <= kind_next;
        end
        if (rd_en) begin
            kind_row_reg <= kind_mem[bucket];
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            key_mem[bucket] <= key_next;
        end
        if (rd_en) begin
            key_row_reg <= key_mem[bucket];
        end
    end

    // Sequencer: clearing pass, accept, wait for the bucket, decide and write back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && !commit) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == BW'(BUCKETS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        cmd_reg   <= s_tdata[1:0];
                        key_reg   <= s_tdata[33:2];
                        kind_reg  <= s_tuser[0];
                        state_reg <= S_HASHING;
                    end
                end
                S_HASHING: begin
                    if (calc_done) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (commit) begin
                        m_tvalid_reg <= 1'b1;
                        present_reg  <= hit_found;
                        status_reg   <= status_next;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, status_reg, present_reg};

    // An accepted item keeps the input closed until its result has been written back.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input accepted again before the previous item finished");

    // The bucket unit only finishes while the sequencer waits for it.
    a_done_in_hashing: assert property (@(posedge aclk) disable iff (!aresetn)
        calc_done |-> (state_reg == S_HASHING))
        else $error("bucket unit finished outside the hashing wait");

    // A result appears only from the decide step.
    a_result_from_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DECIDE))
        else $error("result item raised outside the decide step");

    // A dropped add never reports the key as present.
    a_drop_means_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(status_reg && present_reg))
        else $error("dropped add reported as present");

    // No item is taken during the clearing pass.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("input ready during the clearing pass");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for hashed_key_set: directed and random add, query and remove items.
module tb_top;
    import hks_pkg::*;

    // The testbench keeps its own copy of the set at the block's default size.
    localparam int SLOT_CNT  = BUCKETS_DEF * WAYS_DEF;
    localparam int POOL_SIZE = 48;
    localparam int RAND_OPS  = 1750;

    // Float bit patterns that exercise the special matching rules.
    localparam logic [31:0] FP_POS_ZERO = 32'h0000_0000;
    localparam logic [31:0] FP_NEG_ZERO = 32'h8000_0000;
    localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;
    localparam logic [31:0] FP_SNAN     = 32'h7F80_0001;
    localparam logic [31:0] FP_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] FP_POS_INF  = 32'h7F80_0000;
    localparam logic [31:0] FP_ONE      = 32'h3F80_0000;

    // One set operation; hold_for_idle makes the sender wait until every result is back.
    typedef struct {
        cmd_t        cmd;
        key_kind_t   kind;
        logic [31:0] key;
        bit          hold_for_idle;
    } set_op_t;

    // Expected reply, with the operation kept alongside for messages.
    typedef struct {
        logic        present;
        status_t     status;
        cmd_t        cmd;
        key_kind_t   kind;
        logic [31:0] key;
    } set_reply_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // Input item: [1:0] command, [33:2] key_bits, [39:34] zero.
    logic [39:0] s_tdata  = '0;
    // [0] key_kind.
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // Result item: [0] was_present, [1] status, [7:2] zero.
    logic [7:0]  m_tdata;

    // Shadow of the set contents. Kind and key are only looked at in valid slots.
    bit          slot_valid [SLOT_CNT];
    key_kind_t   slot_kind  [SLOT_CNT];
    logic [31:0] slot_key   [SLOT_CNT];

    set_op_t     op_q[$];
    set_reply_t  membership_q[$];
    set_op_t     cur_op;
    logic [31:0] key_pool [POOL_SIZE];
    int          ops_accepted = 0;
    int          total_ops    = 0;
    int          mismatches   = 0;
    logic        steady;

    hashed_key_set #(
        .BUCKETS (BUCKETS_DEF),
        .WAYS    (WAYS_DEF)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // During this window of accepted items neither side inserts random gaps (an item that holds
    // for idle still waits), so the block is seen running back to back.
    assign steady = (ops_accepted >= 800) && (ops_accepted < 1100);

    // Multiplicative hash reduced to a bucket number.
    function automatic int bucket_of(logic [31:0] key);
        logic [31:0] h;
        h = key * HASH_MULT;
        return int'(h % BUCKETS_DEF);
    endfunction

    function automatic bit is_nan(logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // Integers match on equal bits. Floats match on equal non-NaN bits, and any two
    // zeros match whatever their signs.
    function automatic bit keys_equal(key_kind_t kind, logic [31:0] a, logic [31:0] b);
        if (kind == KIND_INT)
            return a == b;
        if (is_nan(a) || is_nan(b))
            return 1'b0;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
            return 1'b1;
        return a == b;
    endfunction

    // Applies one operation to the shadow set and returns the reply it must produce.
    function automatic set_reply_t predict_membership(set_op_t op);
        int         base;
        int         hit;
        int         free_way;
        set_reply_t r;
        base     = bucket_of(op.key) * WAYS_DEF;
        hit      = -1;
        free_way = -1;
        for (int w = 0; w < WAYS_DEF; w++) begin
            if (!slot_valid[base + w]) begin
                if (free_way < 0)
                    free_way = w;
            end else if (hit < 0 && slot_kind[base + w] == op.kind &&
                         keys_equal(op.kind, slot_key[base + w], op.key)) begin
                hit = w;
            end
        end
        r.present = (hit >= 0);
        r.status  = STAT_DONE;
        r.cmd     = op.cmd;
        r.kind    = op.kind;
        r.key     = op.key;
        case (op.cmd)
            CMD_ADD: begin
                if (hit < 0) begin
                    if (free_way >= 0) begin
                        slot_valid[base + free_way] = 1'b1;
                        slot_kind[base + free_way]  = op.kind;
                        slot_key[base + free_way]   = op.key;
                    end else begin
                        r.status = STAT_DROPPED;
                    end
                end
            end
            CMD_REMOVE: begin
                if (hit >= 0)
                    slot_valid[base + hit] = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task automatic queue_op(input cmd_t cmd, input key_kind_t kind, input logic [31:0] key,
                            input bit hold);
        set_op_t op;
        op.cmd           = cmd;
        op.kind          = kind;
        op.key           = key;
        op.hold_for_idle = hold;
        op_q.push_back(op);
    endtask

    // Keys come mostly from a small pool crowded into eight buckets, so hits, removals
    // and full buckets are common; the rest are float specials and fully random bits.
    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (sel < 67) begin
            case ($urandom_range(0, 6))
                0: return FP_POS_ZERO;
                1: return FP_NEG_ZERO;
                2: return FP_QNAN;
                3: return FP_SNAN;
                4: return FP_ALL_ONES;
                5: return FP_POS_INF;
                default: return FP_ONE;
            endcase
        end
        return $urandom;
    endfunction

    function automatic cmd_t pick_cmd();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return CMD_ADD;
        if (sel < 62)
            return CMD_QUERY;
        if (sel < 95)
            return CMD_REMOVE;
        return CMD_SPARE;
    endfunction

    // Sender. An item stays on the bus until it is taken; outside the steady window new items
    // are offered with random gaps, and items that hold for idle wait for the block to drain.
    always @(posedge aclk) begin : drive_ops
        bit offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                membership_q.push_back(predict_membership(cur_op));
                ops_accepted++;
            end
            if (!(s_tvalid && !s_tready)) begin
                offer = (op_q.size() != 0) && (steady || $urandom_range(0, 99) >= 14);
                if (offer && op_q[0].hold_for_idle && membership_q.size() != 0)
                    offer = 1'b0;
                if (offer) begin
                    cur_op   = op_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'd0, cur_op.key, cur_op.cmd};
                    s_tuser  <= cur_op.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Each result is checked against the oldest expected reply.
    always @(posedge aclk) begin : check_replies
        set_reply_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (membership_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result tdata %h", m_tdata));
                end else begin
                    want = membership_q.pop_front();
                    if (m_tdata[0] !== want.present)
                        report_mismatch($sformatf(
                            "was_present %b, expected %b (%s kind %0d key %h)",
                            m_tdata[0], want.present, want.cmd.name(), want.kind, want.key));
                    if (m_tdata[1] !== want.status)
                        report_mismatch($sformatf(
                            "status %b, expected %b (%s kind %0d key %h)",
                            m_tdata[1], want.status, want.cmd.name(), want.kind, want.key));
                end
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 14);
        end
    end

    // Stimulus and end of run.
    initial begin : run_sequence
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {26'($urandom_range(0, 32'h03FF_FFFF)), 6'((i % 8) * 7 + 3)};

        // Zeros, NaNs and the key kinds all land in bucket zero, next to integer zero.
        queue_op(CMD_QUERY,  KIND_INT,   32'd0,       1'b0);
        queue_op(CMD_ADD,    KIND_INT,   32'd0,       1'b0);
        queue_op(CMD_ADD,    KIND_INT,   32'd0,       1'b0);
        queue_op(CMD_QUERY,  KIND_FLOAT, FP_POS_ZERO, 1'b0);
        queue_op(CMD_ADD,    KIND_FLOAT, FP_NEG_ZERO, 1'b0);
        queue_op(CMD_QUERY,  KIND_FLOAT, FP_POS_ZERO, 1'b0);
        queue_op(CMD_REMOVE, KIND_FLOAT, FP_POS_ZERO, 1'b0);
        queue_op(CMD_QUERY,  KIND_FLOAT, FP_NEG_ZERO, 1'b0);
        // A NaN never matches, so each add takes another way.
        queue_op(CMD_ADD,    KIND_FLOAT, FP_QNAN,     1'b0);
        queue_op(CMD_ADD,    KIND_FLOAT, FP_QNAN,     1'b0);
        queue_op(CMD_QUERY,  KIND_FLOAT, FP_QNAN,     1'b0);
        queue_op(CMD_REMOVE, KIND_FLOAT, FP_QNAN,     1'b0);
        // Bucket zero now holds three entries; one more fills it and the next is dropped.
        queue_op(CMD_ADD,    KIND_INT,   32'd64,      1'b0);
        queue_op(CMD_ADD,    KIND_INT,   32'd128,     1'b0);
        queue_op(CMD_REMOVE, KIND_INT,   32'd64,      1'b0);
        queue_op(CMD_ADD,    KIND_INT,   32'd128,     1'b0);
        queue_op(CMD_SPARE,  KIND_INT,   32'd128,     1'b0);
        // Extremes of the key field and the all-ones and infinity float patterns.
        queue_op(CMD_ADD,    KIND_INT,   32'hFFFF_FFFF, 1'b0);
        queue_op(CMD_ADD,    KIND_FLOAT, FP_ALL_ONES,   1'b0);
        queue_op(CMD_QUERY,  KIND_FLOAT, FP_ALL_ONES,   1'b0);
        queue_op(CMD_ADD,    KIND_INT,   32'h7FFF_FFFF, 1'b0);
        queue_op(CMD_QUERY,  KIND_INT,   32'h8000_0000, 1'b0);
        queue_op(CMD_ADD,    KIND_FLOAT, FP_POS_INF,    1'b0);
        queue_op(CMD_SPARE,  KIND_FLOAT, FP_POS_INF,    1'b0);
        queue_op(CMD_REMOVE, KIND_INT,   32'hFFFF_FFFF, 1'b0);

        // Random part. Now and then the sender lets the block drain completely first.
        for (int i = 0; i < RAND_OPS; i++)
            queue_op(pick_cmd(), key_kind_t'($urandom_range(0, 1)), pick_key(),
                     (i % 400) == 0);
        total_ops = op_q.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (ops_accepted != total_ops)
            @(posedge aclk);
        while (membership_q.size() != 0)
            @(posedge aclk);
        // Any stray result after the last expected one is caught by the receiver.
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && membership_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop far beyond the slowest correct run, including the clearing pass.
    initial begin : watchdog
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
